// File: rtl/lpps_pkg.sv
// ----------------------------------------------------------------------------
// lpps_pkg
// Shared types and constants for the line position PD steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpps_pkg;

   // sensor lanes and their centroid weights, outermost left first
   localparam int NUM_LANES   = 8;
   localparam int WEIGHT_BITS = 4;
   localparam logic signed [WEIGHT_BITS-1:0] LANE_WEIGHT [NUM_LANES] = '{
      -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4
   };

   // fixed field widths
   localparam int SETP_BITS = 12;
   localparam int GAIN_BITS = 16;
   localparam int BASE_BITS = 10;
   localparam int ERR_BITS  = 13;
   localparam int DIFF_BITS = ERR_BITS + 1;
   localparam int FRAC_BITS = 8;              // Q.8 position
   localparam int QUO_BITS  = 11;             // |position| <= 1024
   localparam int POS_BITS  = QUO_BITS + 1;
   localparam int CNT_BITS  = $clog2(QUO_BITS + 1);
   localparam int ACC_FRAC  = 16;             // PD term in Q.16
   localparam int TERM_BITS = 32;
   localparam int RAW_BITS  = 34;

   // configuration port
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETPOINT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PROP_GAIN  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_LEFT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_RIGHT = 3'd4;

   // register reset values
   localparam logic signed [SETP_BITS-1:0] SETPOINT_RST   = 12'sd166;
   localparam logic [GAIN_BITS-1:0]        PROP_GAIN_RST  = 16'd28160;
   localparam logic [GAIN_BITS-1:0]        DERIV_GAIN_RST = 16'd26;
   localparam logic [BASE_BITS-1:0]        BASE_LEFT_RST  = 10'd100;
   localparam logic [BASE_BITS-1:0]        BASE_RIGHT_RST = 10'd100;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } lpps_div_stat_type;

endpackage

`default_nettype wire

// File: rtl/lpps_lane.sv
// ----------------------------------------------------------------------------
// lpps_lane
// One sensor lane: registers the sample and its weighted product.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_lane
   import lpps_pkg::*;
#(
   parameter int SAMPLE_BITS = 12,
   parameter logic signed [WEIGHT_BITS-1:0] WEIGHT = 4'sd1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [SAMPLE_BITS-1:0]        in_sample,
   output logic                               out_valid,
   output logic [SAMPLE_BITS-1:0]             out_sample,
   output logic signed [SAMPLE_BITS+3:0]      out_prod
);

   logic                          valid_ff;
   logic [SAMPLE_BITS-1:0]        sample_ff;
   logic signed [SAMPLE_BITS+3:0] prod_ff;
   logic signed [SAMPLE_BITS+3:0] prod_in;

   // |weight| <= 4, so the product needs two bits above the sample plus sign
   assign prod_in = $signed({1'b0, in_sample}) * WEIGHT;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         sample_ff <= in_sample;
         prod_ff   <= prod_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sample = sample_ff;
   assign out_prod   = prod_ff;

endmodule

`default_nettype wire

// File: rtl/lpps_merge.sv
// ----------------------------------------------------------------------------
// lpps_merge
// Two-level registered adder tree: sample sum and weighted sum of the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_merge
   import lpps_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire logic [SAMPLE_BITS-1:0]          in_sample [NUM_LANES],
   input  wire logic signed [SAMPLE_BITS+3:0]   in_prod [NUM_LANES],
   output logic                                 out_valid,
   output logic [SAMPLE_BITS+2:0]               out_sum,
   output logic signed [SAMPLE_BITS+4:0]        out_num
);

   localparam int PAIRS = NUM_LANES / 2;
   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int NUM_W = SAMPLE_BITS + 5;

   logic                    va_ff;
   logic                    vb_ff;
   logic [SAMPLE_BITS:0]    psum_ff [PAIRS];
   logic signed [NUM_W-1:0] pnum_ff [PAIRS];
   logic [SUM_W-1:0]        sum_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [SUM_W-1:0]        sum_in;
   logic signed [NUM_W-1:0] num_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         for (int i = 0; i < PAIRS; i++) begin
            psum_ff[i] <= {1'b0, in_sample[2*i]} + {1'b0, in_sample[2*i+1]};
            pnum_ff[i] <= NUM_W'(in_prod[2*i]) + NUM_W'(in_prod[2*i+1]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      num_in = '0;
      for (int i = 0; i < PAIRS; i++) begin
         sum_in = sum_in + SUM_W'(psum_ff[i]);
         num_in = num_in + pnum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (va_ff) begin
         sum_ff <= sum_in;
         num_ff <= num_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_sum   = sum_ff;
   assign out_num   = num_ff;

endmodule

`default_nettype wire

// File: rtl/lpps_div.sv
// ----------------------------------------------------------------------------
// lpps_div
// Restoring divider, one quotient bit a cycle: (num * 256) / sum, truncated
// toward zero. Zero sum gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_div
   import lpps_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic signed [SAMPLE_BITS+4:0]  num,
   input  wire logic [SAMPLE_BITS+2:0]         den,
   output lpps_div_stat_type                   stat,
   output logic signed [POS_BITS-1:0]          quo
);

   localparam int NUM_W = SAMPLE_BITS + 5;
   localparam int DEN_W = SAMPLE_BITS + 3;
   localparam int MAG_W = SAMPLE_BITS + 4;
   localparam int REM_W = SAMPLE_BITS + 4;
   localparam int SHF_W = MAG_W + FRAC_BITS;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [QUO_BITS-1:0] dvd_ff;
   logic [QUO_BITS-1:0] quo_ff;
   logic [DEN_W-1:0]    den_ff;

   logic [NUM_W-1:0]    num_abs;
   logic [SHF_W-1:0]    shifted;
   logic [REM_W-1:0]    trial;
   logic                fits;

   assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign shifted = {num_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};

   // remainder stays below den, so its top bit is free for the shift
   assign trial = {rem_ff[REM_W-2:0], dvd_ff[QUO_BITS-1]};
   assign fits  = trial >= REM_W'(den_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = (den != '0);
         done_in = (den == '0);
      end else if (busy_ff && cnt_ff == CNT_BITS'(1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[NUM_W-1];
         den_ff <= den;
         cnt_ff <= CNT_BITS'(QUO_BITS);
         // quotient < 2^11, so the top dividend bits already sit below den
         rem_ff <= REM_W'(shifted[SHF_W-1:QUO_BITS]);
         dvd_ff <= shifted[QUO_BITS-1:0];
         quo_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_BITS'(1);
         rem_ff <= fits ? trial - REM_W'(den_ff) : trial;
         dvd_ff <= {dvd_ff[QUO_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_BITS-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quo = neg_ff ? POS_BITS'(-$signed({1'b0, quo_ff})) : $signed({1'b0, quo_ff});

endmodule

`default_nettype wire

// File: rtl/lpps_pd.sv
// ----------------------------------------------------------------------------
// lpps_pd
// Error, PD term and clamped left/right duties, five register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_pd
   import lpps_pkg::*;
#(
   parameter int DUTY_BITS = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [POS_BITS-1:0]    position,
   input  wire logic signed [SETP_BITS-1:0]   setpoint,
   input  wire logic [GAIN_BITS-1:0]          prop_gain,
   input  wire logic [GAIN_BITS-1:0]          deriv_gain,
   input  wire logic [BASE_BITS-1:0]          base_left,
   input  wire logic [BASE_BITS-1:0]          base_right,
   output logic                               out_valid,
   output logic [DUTY_BITS-1:0]               left_duty,
   output logic [DUTY_BITS-1:0]               right_duty,
   output logic signed [ERR_BITS-1:0]         line_error
);

   localparam int HI_BITS = RAW_BITS - ACC_FRAC;
   localparam logic [DUTY_BITS-1:0] DUTY_TOP = {DUTY_BITS{1'b1}};

   logic                           v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [ERR_BITS-1:0]     last_err_ff;
   logic signed [ERR_BITS-1:0]     err1_ff, err2_ff, err3_ff, err4_ff, err5_ff;
   logic signed [DIFF_BITS-1:0]    diff_ff;
   logic signed [TERM_BITS-1:0]    pterm_ff, dterm_ff, acc_ff;
   logic signed [RAW_BITS-1:0]     raw_l_ff, raw_r_ff;
   logic [DUTY_BITS-1:0]           left_ff, right_ff;

   logic signed [ERR_BITS-1:0]     err_in;
   logic signed [RAW_BITS-1:0]     base_l_ext, base_r_ext;

   assign err_in = ERR_BITS'(setpoint) - ERR_BITS'(position);

   assign base_l_ext = $signed({{(RAW_BITS-BASE_BITS-ACC_FRAC){1'b0}}, base_left,
                                {ACC_FRAC{1'b0}}});
   assign base_r_ext = $signed({{(RAW_BITS-BASE_BITS-ACC_FRAC){1'b0}}, base_right,
                                {ACC_FRAC{1'b0}}});

   function automatic logic [DUTY_BITS-1:0] clamp(input logic signed [RAW_BITS-1:0] raw);
      logic [HI_BITS-1:0] hi;
      hi = raw[RAW_BITS-1:ACC_FRAC];
      if (raw[RAW_BITS-1]) begin
         clamp = '0;
      end else if (hi > HI_BITS'(DUTY_TOP)) begin
         clamp = DUTY_TOP;
      end else begin
         clamp = hi[DUTY_BITS-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         v5_ff       <= 1'b0;
         last_err_ff <= '0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         if (in_valid) begin
            last_err_ff <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         err1_ff <= err_in;
         diff_ff <= DIFF_BITS'(err_in) - DIFF_BITS'(last_err_ff);
      end
      if (v1_ff) begin
         err2_ff  <= err1_ff;
         pterm_ff <= $signed({1'b0, prop_gain}) * err1_ff;
         dterm_ff <= $signed({1'b0, deriv_gain}) * diff_ff;
      end
      if (v2_ff) begin
         err3_ff <= err2_ff;
         acc_ff  <= pterm_ff + dterm_ff;
      end
      if (v3_ff) begin
         err4_ff  <= err3_ff;
         raw_l_ff <= base_l_ext + RAW_BITS'(acc_ff);
         raw_r_ff <= base_r_ext - RAW_BITS'(acc_ff);
      end
      if (v4_ff) begin
         err5_ff  <= err4_ff;
         left_ff  <= clamp(raw_l_ff);
         right_ff <= clamp(raw_r_ff);
      end
   end

   assign out_valid  = v5_ff;
   assign left_duty  = left_ff;
   assign right_duty = right_ff;
   assign line_error = err5_ff;

endmodule

`default_nettype wire

// File: rtl/line_position_pd_steering.sv
// ----------------------------------------------------------------------------
// line_position_pd_steering
// Line follower steering: weighted centroid of eight sensor samples, PD
// correction on the position error, clamped left and right motor duties.
// ----------------------------------------------------------------------------
//
//   channel   direction  word                                   handshake
//   req_      in         eight samples, sense_m4 lowest         tvalid/tready
//   rsp_      out        left_duty, right_duty, line_error      tvalid/tready
//   csr_      in         register index + write data            valid/ready
//
// One frame at a time: the next accept waits until the result of the last
// frame has been loaded into the output register; most of that time goes to
// the eleven-step centroid divider, and a frame whose samples sum to zero
// skips the divider.
// Synchronous active-high reset clears control state, the registers to their
// defaults and the previous error to zero.
// A result waiting on rsp_ does not block the next frame; only a second
// result backs up into the holding register and holds req_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_pd_steering
   import lpps_pkg::*;
#(
   parameter int SAMPLE_BITS = 12,
   parameter int DUTY_BITS   = 10
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   // sense_m4, sense_m3, sense_m2, sense_m1, sense_p1, sense_p2, sense_p3, sense_p4
   input  wire logic [NUM_LANES*SAMPLE_BITS-1:0]              req_tdata,
   input  wire logic                                          req_tvalid,
   output logic                                               req_tready,
   // left_duty, right_duty, line_error, zero pad
   output logic [((2*DUTY_BITS+ERR_BITS+7)/8)*8-1:0]          rsp_tdata,
   output logic                                               rsp_tvalid,
   input  wire logic                                          rsp_tready,
   input  wire logic                                          csr_valid,
   output logic                                               csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]                       csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]                      csr_wdata
);

   localparam int DATA_W = 2 * DUTY_BITS + ERR_BITS;
   localparam int RSP_W  = ((DATA_W + 7) / 8) * 8;

   // configuration registers
   logic signed [SETP_BITS-1:0] setpoint_ff;
   logic [GAIN_BITS-1:0]        prop_gain_ff;
   logic [GAIN_BITS-1:0]        deriv_gain_ff;
   logic [BASE_BITS-1:0]        base_left_ff;
   logic [BASE_BITS-1:0]        base_right_ff;

   // datapath
   logic                                req_fire;
   logic [NUM_LANES-1:0]                lane_v;
   logic [SAMPLE_BITS-1:0]              lane_sample [NUM_LANES];
   logic signed [SAMPLE_BITS+3:0]       lane_prod [NUM_LANES];
   logic                                merge_valid;
   logic [SAMPLE_BITS+2:0]              merge_sum;
   logic signed [SAMPLE_BITS+4:0]       merge_num;
   lpps_div_stat_type                   div_stat;
   logic signed [POS_BITS-1:0]          div_quo;
   logic                                pd_valid;
   logic [DUTY_BITS-1:0]                pd_left;
   logic [DUTY_BITS-1:0]                pd_right;
   logic signed [ERR_BITS-1:0]          pd_err;
   logic [DATA_W-1:0]                   pd_word;

   // output register and holding register
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              pend_valid_ff, pend_valid_in;
   logic [DATA_W-1:0] pend_data_ff;
   logic              rsp_free;
   logic              load_pend;
   logic              load_pd;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // register writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff   <= SETPOINT_RST;
         prop_gain_ff  <= PROP_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
         base_left_ff  <= BASE_LEFT_RST;
         base_right_ff <= BASE_RIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SETPOINT:   setpoint_ff   <= $signed(csr_wdata[SETP_BITS-1:0]);
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[GAIN_BITS-1:0];
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata[GAIN_BITS-1:0];
            CSR_BASE_LEFT:  base_left_ff  <= csr_wdata[BASE_BITS-1:0];
            CSR_BASE_RIGHT: base_right_ff <= csr_wdata[BASE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // eight lanes, one per sensor
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      lpps_lane #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .WEIGHT      (LANE_WEIGHT[i])
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (req_fire),
         .in_sample  (req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
         .out_valid  (lane_v[i]),
         .out_sample (lane_sample[i]),
         .out_prod   (lane_prod[i])
      );
   end

   lpps_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (&lane_v),
      .in_sample (lane_sample),
      .in_prod   (lane_prod),
      .out_valid (merge_valid),
      .out_sum   (merge_sum),
      .out_num   (merge_num)
   );

   lpps_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (merge_valid),
      .num   (merge_num),
      .den   (merge_sum),
      .stat  (div_stat),
      .quo   (div_quo)
   );

   lpps_pd #(
      .DUTY_BITS (DUTY_BITS)
   ) u_pd (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_stat.done),
      .position   (div_quo),
      .setpoint   (setpoint_ff),
      .prop_gain  (prop_gain_ff),
      .deriv_gain (deriv_gain_ff),
      .base_left  (base_left_ff),
      .base_right (base_right_ff),
      .out_valid  (pd_valid),
      .left_duty  (pd_left),
      .right_duty (pd_right),
      .line_error (pd_err)
   );

   assign pd_word = {pd_err, pd_right, pd_left};

   // output side: a fresh result goes straight to rsp_ when it is free,
   // otherwise it waits in the holding register
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign load_pend = pend_valid_ff && rsp_free;
   assign load_pd   = pd_valid && rsp_free && !pend_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      pend_valid_in = pend_valid_ff;
      busy_in       = busy_ff;
      if (rsp_free) begin
         rsp_valid_in = pend_valid_ff || pd_valid;
      end
      if (load_pend) begin
         pend_valid_in = 1'b0;
      end else if (pd_valid && !rsp_free) begin
         pend_valid_in = 1'b1;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (load_pend || load_pd) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_pend) begin
         rsp_data_ff <= pend_data_ff;
      end else if (load_pd) begin
         rsp_data_ff <= pd_word;
      end
      if (pd_valid && !rsp_free) begin
         pend_data_ff <= pd_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   // ---- assertions ----

   // a result never lands on a full holding register
   a_pend_room: assert property (@(posedge clock) disable iff (reset)
      pd_valid |-> !pend_valid_ff)
      else $error("PD result arrived with holding register full");

   // a held result always belongs to the frame in flight
   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> busy_ff)
      else $error("holding register full while idle");

   // only one frame is ever in the datapath
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      $onehot0({&lane_v, merge_valid, div_stat.busy, pd_valid}))
      else $error("more than one frame in the datapath");

   // the divider finishes only for an accepted frame
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> busy_ff)
      else $error("divider done with no frame in flight");

endmodule

`default_nettype wire

// File: bench/line_position_pd_steering_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_position_pd_steering_tb
// Self-checking bench for the line position PD steering block. Sensor frames
// go in on req_ and each gets a steering prediction from a local centroid and
// PD calculation. Every rsp_ word is then compared with the oldest prediction.
// Directed corner frames and register extremes come first, then random
// frames under changing register settings and random idling on both sides.
// ----------------------------------------------------------------------------

module line_position_pd_steering_tb;
   import lpps_pkg::*;

   localparam int SAMPLE_BITS      = 12;
   localparam int DUTY_BITS        = 10;
   localparam int SAMPLE_MAX       = (1 << SAMPLE_BITS) - 1;
   localparam int DUTY_MAX         = (1 << DUTY_BITS) - 1;
   localparam int RSP_BITS         = ((2*DUTY_BITS+ERR_BITS+7)/8)*8;
   localparam int CYCLE_LIMIT      = 600000;  // watchdog bound on the whole run
   localparam int TAIL_CYCLES      = 40;      // longer than any frame takes, zero sum or full
   localparam int IDLE_MAX         = 12;
   localparam int RANDOM_PHASES    = 10;
   localparam int FRAMES_PER_PHASE = 185;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LAST_INDEX = '1;

   // one frame: lane 0 (sense_m4) in the lowest bits, as on req_tdata
   typedef logic [NUM_LANES-1:0][SAMPLE_BITS-1:0] frame_type;

   // rsp_ word without the pad, left_duty lowest
   typedef struct packed {
      logic signed [ERR_BITS-1:0] line_error;
      logic [DUTY_BITS-1:0]       right_duty;
      logic [DUTY_BITS-1:0]       left_duty;
   } steer_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   // sense_m4, sense_m3, sense_m2, sense_m1, sense_p1, sense_p2, sense_p3, sense_p4
   logic [NUM_LANES*SAMPLE_BITS-1:0] req_tdata  = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // left_duty, right_duty, line_error, zero pad
   logic [RSP_BITS-1:0]              rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [CSR_IDX_BITS-1:0]          csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]         csr_wdata  = '0;

   // local copy of the block's registers and previous error
   logic signed [SETP_BITS-1:0] setpoint_q   = SETPOINT_RST;
   logic [GAIN_BITS-1:0]        prop_gain_q  = PROP_GAIN_RST;
   logic [GAIN_BITS-1:0]        deriv_gain_q = DERIV_GAIN_RST;
   logic [BASE_BITS-1:0]        base_left_q  = BASE_LEFT_RST;
   logic [BASE_BITS-1:0]        base_right_q = BASE_RIGHT_RST;
   logic signed [ERR_BITS-1:0]  prev_error_q = '0;

   steer_type pending_steer[$];  // predictions still waiting for their rsp_ word
   int     mismatch_count = 0;
   int     cycle_count    = 0;

   // idling controls: upper bound of the per-word wait on each side
   int     tx_gap_max   = IDLE_MAX;
   int     rx_stall_max = IDLE_MAX;
   int     tx_gap       = 0;     // wait drawn at the last accept, for the next word
   bit     tx_hold      = 1'b0;  // tvalid stays high straight into the next word

   line_position_pd_steering #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DUTY_BITS   (DUTY_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // drop the 16 fraction bits of a Q.16 duty, clamp to 0..DUTY_MAX
   function automatic logic [DUTY_BITS-1:0] clamp_duty(longint raw);
      longint whole;
      if (raw < 0)
         return '0;
      whole = raw >>> ACC_FRAC;
      if (whole > DUTY_MAX)
         return '1;
      return whole[DUTY_BITS-1:0];
   endfunction

   // centroid, error and PD steering for one frame; advances the previous error
   function automatic steer_type predict_steering(frame_type f);
      longint moment, total, position, err, pd_term;
      steer_type r;
      moment = 0;
      total  = 0;
      for (int i = 0; i < NUM_LANES; i++) begin
         total  += longint'(f[i]);
         moment += longint'(LANE_WEIGHT[i]) * longint'(f[i]);
      end
      // Q.8 position, truncated toward zero; no line seen means centre
      position = (total != 0) ? (moment * (1 << FRAC_BITS)) / total : 0;
      err      = longint'(setpoint_q) - position;
      pd_term  = longint'(prop_gain_q) * err
               + longint'(deriv_gain_q) * (err - longint'(prev_error_q));
      r.left_duty  = clamp_duty((longint'(base_left_q) << ACC_FRAC) + pd_term);
      r.right_duty = clamp_duty((longint'(base_right_q) << ACC_FRAC) - pd_term);
      r.line_error = err[ERR_BITS-1:0];
      prev_error_q = err[ERR_BITS-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Register writes (only ever issued with nothing in flight)
   // ------------------------------------------------------------------------

   // csr_valid is left high so that back-to-back writes need no gap
   task automatic csr_put(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SETPOINT:   setpoint_q   = data[SETP_BITS-1:0];
         CSR_PROP_GAIN:  prop_gain_q  = data[GAIN_BITS-1:0];
         CSR_DERIV_GAIN: deriv_gain_q = data[GAIN_BITS-1:0];
         CSR_BASE_LEFT:  base_left_q  = data[BASE_BITS-1:0];
         CSR_BASE_RIGHT: base_right_q = data[BASE_BITS-1:0];
         default: ;      // unmapped index: block ignores it
      endcase
   endtask

   task automatic program_regs(logic [CSR_DATA_BITS-1:0] sp, logic [CSR_DATA_BITS-1:0] kp,
                               logic [CSR_DATA_BITS-1:0] kd, logic [CSR_DATA_BITS-1:0] bl,
                               logic [CSR_DATA_BITS-1:0] br);
      csr_put(CSR_SETPOINT, sp);
      csr_put(CSR_PROP_GAIN, kp);
      csr_put(CSR_DERIV_GAIN, kd);
      csr_put(CSR_BASE_LEFT, bl);
      csr_put(CSR_BASE_RIGHT, br);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Frame sender and result checker
   // ------------------------------------------------------------------------

   function automatic int draw_wait(int max_wait);
      // at least a quarter of the draws are zero so runs without idling turn up too
      if (max_wait == 0 || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, max_wait);
   endfunction

   // The wait before the next word is drawn at each accept, so tvalid is
   // either kept high or dropped once in that step, never both. A frame
   // marked as the end of a burst always drops tvalid.
   task automatic send_frame(frame_type f, bit end_of_burst);
      if (!tx_hold)
         repeat (tx_gap) @(posedge clock);
      req_tdata  <= f;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_steer.push_back(predict_steering(f));
      tx_gap  = draw_wait(tx_gap_max);
      tx_hold = !end_of_burst && tx_gap == 0;
      if (!tx_hold)
         req_tvalid <= 1'b0;
   endtask

   // every frame gives exactly one word, so an empty queue means idle
   task automatic wait_all_results();
      while (pending_steer.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_result(steer_type got);
      steer_type want;
      if (pending_steer.size() == 0) begin
         $error("rsp_ word with no frame outstanding: %h", got);
         mismatch_count++;
         return;
      end
      want = pending_steer.pop_front();
      if (got.left_duty !== want.left_duty) begin
         $error("left_duty: expected %0d, actual %0d", want.left_duty, got.left_duty);
         mismatch_count++;
      end
      if (got.right_duty !== want.right_duty) begin
         $error("right_duty: expected %0d, actual %0d", want.right_duty, got.right_duty);
         mismatch_count++;
      end
      if (got.line_error !== want.line_error) begin
         $error("line_error: expected %0d, actual %0d", want.line_error, got.line_error);
         mismatch_count++;
      end
   endtask

   // receiver: random stall before each word, same one-assignment rule as the sender
   initial begin
      int stall;
      while (reset)
         @(posedge clock);
      forever begin
         stall = draw_wait(rx_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_result(steer_type'(rsp_tdata[2*DUTY_BITS+ERR_BITS-1:0]));
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   function automatic frame_type random_frame();
      frame_type f;
      int     centre, peak, spread;
      f = '0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin          // anything goes
            for (int i = 0; i < NUM_LANES; i++)
               f[i] = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
         end
         4, 5: begin                // a line under one lane, spill-over and noise around it
            centre = $urandom_range(0, NUM_LANES - 1);
            peak   = $urandom_range(0, SAMPLE_MAX);
            for (int i = 0; i < NUM_LANES; i++) begin
               spread = (i > centre) ? i - centre : centre - i;
               if (spread == 0)
                  f[i] = SAMPLE_BITS'(peak);
               else if (spread == 1)
                  f[i] = SAMPLE_BITS'(peak / 2 + $urandom_range(0, 63));
               else
                  f[i] = SAMPLE_BITS'($urandom_range(0, 63));
            end
         end
         6: begin                   // sparse
            for (int i = 0; i < NUM_LANES; i++)
               if ($urandom_range(0, 1) == 1)
                  f[i] = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
         end
         7: f[$urandom_range(0, NUM_LANES - 1)] = SAMPLE_BITS'($urandom_range(1, SAMPLE_MAX));
         8: begin                   // near-dark, sum can be zero
            for (int i = 0; i < NUM_LANES; i++)
               f[i] = SAMPLE_BITS'($urandom_range(0, 3));
         end
         default: begin             // each lane at a corner value
            for (int i = 0; i < NUM_LANES; i++)
               case ($urandom_range(0, 3))
                  0: f[i] = '0;
                  1: f[i] = '1;
                  2: f[i] = SAMPLE_BITS'(1);
                  default: f[i] = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
               endcase
         end
      endcase
      return f;
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_gain();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return CSR_DATA_BITS'($urandom_range(0, 1023));  // small gain, small PD swing
         default: return CSR_DATA_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // all five registers, with the odd write to an unmapped index mixed in
   task automatic random_settings();
      logic [CSR_DATA_BITS-1:0] sp;
      case ($urandom_range(0, 3))
         0: sp = CSR_DATA_BITS'($urandom_range(0, 65535));         // upper bits dropped
         1, 2: sp = CSR_DATA_BITS'($urandom_range(0, 2048) - 1024);
         default: sp = ($urandom_range(0, 1) == 1) ? 16'sd1024 : -16'sd1024;
      endcase
      csr_put(CSR_SETPOINT, sp);
      csr_put(CSR_PROP_GAIN, random_gain());
      if ($urandom_range(0, 2) == 0)
         csr_put(CSR_IDX_BITS'($urandom_range(int'(CSR_BASE_RIGHT) + 1, int'(CSR_LAST_INDEX))),
                 CSR_DATA_BITS'($urandom_range(0, 65535)));
      csr_put(CSR_DERIV_GAIN, random_gain());
      csr_put(CSR_BASE_LEFT, CSR_DATA_BITS'($urandom_range(0, 65535)));
      csr_put(CSR_BASE_RIGHT, CSR_DATA_BITS'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // straight out of reset: default registers, zero previous error
   task automatic test_reset_defaults();
      frame_type f;
      f = '0;
      send_frame(f, 1'b0);                    // zero sum: position 0
      f = '0;
      f[4] = 12'd3000;
      f[3] = 12'd1200;
      f[5] = 12'd400;
      send_frame(f, 1'b0);
      send_frame('1, 1'b1);                   // all lanes full scale
      wait_all_results();
   endtask

   // centroid corners under unity gains so the duties stay in range
   task automatic test_centroid_corners();
      frame_type f;
      program_regs(16'sd0, 16'd256, 16'd256, 16'd512, 16'd512);
      for (int i = 0; i < NUM_LANES; i++) begin
         f = '0;
         f[i] = '1;                           // single lane: -1024 .. +1024
         send_frame(f, 1'b0);
      end
      f = '0;
      f[0] = 12'd1;
      f[4] = 12'd2;                           // -512/3: truncation toward zero
      send_frame(f, 1'b0);
      f = '0;
      f[0] = '1;
      f[7] = 12'd1;
      send_frame(f, 1'b0);
      f = {NUM_LANES{12'hAAA}};
      send_frame(f, 1'b0);
      f = {NUM_LANES{12'h555}};
      send_frame(f, 1'b1);
      wait_all_results();
   endtask

   // register limits, masking of over-wide writes and unmapped indexes
   task automatic test_register_extremes();
      frame_type f;
      // setpoint 2047 (upper bits dropped), gains at the top, bases split
      program_regs(16'hF7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      f = '0;
      send_frame(f, 1'b0);
      f[7] = '1;
      send_frame(f, 1'b1);
      wait_all_results();
      // setpoint -2048, no gain at all: duties are the bases
      program_regs(16'h0800, 16'h0000, 16'h0000, 16'h0000, 16'hFC00 | 16'd1023);
      @(posedge clock);
      for (int idx = int'(CSR_BASE_RIGHT) + 1; idx <= int'(CSR_LAST_INDEX); idx++)
         csr_put(CSR_IDX_BITS'(idx), CSR_DATA_BITS'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
      f = '0;
      f[0] = '1;
      send_frame(f, 1'b0);
      send_frame('1, 1'b1);
      wait_all_results();
      // setpoint at the ends of the normal range, derivative only, then proportional only
      program_regs(-16'sd1024, 16'h0000, 16'hFFFF, 16'd1023, 16'd1023);
      f = '0;
      f[7] = '1;
      send_frame(f, 1'b0);
      f = '0;
      f[0] = '1;
      send_frame(f, 1'b1);
      wait_all_results();
      program_regs(16'sd1024, 16'hFFFF, 16'h0000, 16'd0, 16'd0);
      f = '0;
      f[0] = '1;
      send_frame(f, 1'b0);
      f = '0;
      f[7] = '1;
      send_frame(f, 1'b1);
      wait_all_results();
   endtask

   // phases of random frames; each phase gets new registers and its own idling
   // mix, and the sender now and then holds off until every word is back
   task automatic test_random_traffic();
      frame_type f;
      bit     end_of_burst;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin tx_gap_max = IDLE_MAX; rx_stall_max = IDLE_MAX; end
            1: begin tx_gap_max = 0;        rx_stall_max = 0;        end
            2: begin tx_gap_max = IDLE_MAX; rx_stall_max = 0;        end
            default: begin tx_gap_max = 0;  rx_stall_max = IDLE_MAX; end
         endcase
         random_settings();
         for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
            f = random_frame();
            end_of_burst = (i == FRAMES_PER_PHASE - 1) || ($urandom_range(0, 63) == 0);
            send_frame(f, end_of_burst);
            if (end_of_burst)
               wait_all_results();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_centroid_corners();
      test_register_extremes();
      test_random_traffic();
      wait_all_results();
      // let any stray word show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_steer.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
